// ===== hw/rtl/vmsa_pkg.sv =====
// vmsa_pkg: shared types and constants for the vm stack alu with segments
// operation and status codes, stack cell shift control, segment request struct
// no dependencies
package vmsa_pkg;

  localparam int DEF_STACK_DEPTH   = 256;
  localparam int DEF_SEGMENT_WORDS = 256;
  localparam int DEF_WORD_BITS     = 16;

  localparam int SEG_COUNT  = 7;
  localparam int OP_BITS    = 4;
  localparam int IO_BITS    = 16;
  localparam int SEL_BITS   = 3;
  localparam int IDX_BITS   = 8;
  localparam int STAT_BITS  = 2;

  localparam logic [OP_BITS-1:0] OP_PUSH     = 4'd0;
  localparam logic [OP_BITS-1:0] OP_POP      = 4'd1;
  localparam logic [OP_BITS-1:0] OP_ADD      = 4'd2;
  localparam logic [OP_BITS-1:0] OP_SUB      = 4'd3;
  localparam logic [OP_BITS-1:0] OP_NEG      = 4'd4;
  localparam logic [OP_BITS-1:0] OP_EQ       = 4'd5;
  localparam logic [OP_BITS-1:0] OP_GT       = 4'd6;
  localparam logic [OP_BITS-1:0] OP_LT       = 4'd7;
  localparam logic [OP_BITS-1:0] OP_AND      = 4'd8;
  localparam logic [OP_BITS-1:0] OP_OR       = 4'd9;
  localparam logic [OP_BITS-1:0] OP_NOT      = 4'd10;
  localparam logic [OP_BITS-1:0] OP_SEGWRITE = 4'd11;
  localparam logic [OP_BITS-1:0] OP_SEGREAD  = 4'd12;

  localparam logic [STAT_BITS-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_BITS-1:0] ST_UNDERFLOW = 2'd1;
  localparam logic [STAT_BITS-1:0] ST_OVERFLOW  = 2'd2;

  typedef enum logic [1:0] {
    SH_HOLD,
    SH_PUSH,
    SH_POP1,
    SH_POP2
  } shift_t;

  typedef struct packed {
    logic wr;
    logic rd;
  } seg_req_t;

endpackage

// ===== hw/rtl/vmsa_ram.sv =====
// vmsa_ram: generic single-port ram with registered read
// no dependencies
module vmsa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem_r[addr] <= wdata;
      end
      rdata_r <= mem_r[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/vmsa_cell.sv =====
// vmsa_cell: one word of the shift-register stack
// takes its word from the neighbour above on push or from below on pop; uses vmsa_pkg
module vmsa_cell #(
  parameter int WORD_BITS = vmsa_pkg::DEF_WORD_BITS
) (
  input  logic                 clk,
  input  vmsa_pkg::shift_t     shift,
  input  logic [WORD_BITS-1:0] up_word,
  input  logic [WORD_BITS-1:0] dn1_word,
  input  logic [WORD_BITS-1:0] dn2_word,
  output logic [WORD_BITS-1:0] word
);
  import vmsa_pkg::*;

  logic [WORD_BITS-1:0] word_r;
  logic [WORD_BITS-1:0] word_nxt;

  always_comb begin
    case (shift)
      SH_PUSH: word_nxt = up_word;
      SH_POP1: word_nxt = dn1_word;
      SH_POP2: word_nxt = dn2_word;
      default: word_nxt = word_r;
    endcase
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign word = word_r;

endmodule

// ===== hw/rtl/vmsa_seg.sv =====
// vmsa_seg: segment store with address check and clearing sweep after reset
// depends on vmsa_pkg and vmsa_ram
module vmsa_seg #(
  parameter int SEGMENT_WORDS = vmsa_pkg::DEF_SEGMENT_WORDS,
  parameter int WORD_BITS     = vmsa_pkg::DEF_WORD_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  vmsa_pkg::seg_req_t            req,
  input  logic [vmsa_pkg::SEL_BITS-1:0] sel,
  input  logic [vmsa_pkg::IDX_BITS-1:0] idx,
  input  logic [WORD_BITS-1:0]          wdata,
  output logic [WORD_BITS-1:0]          rdata,
  output logic                          clearing
);
  import vmsa_pkg::*;

  localparam int DEPTH  = SEG_COUNT * SEGMENT_WORDS;
  localparam int ADDR_W = $clog2(DEPTH);

  logic              clearing_r;
  logic [ADDR_W-1:0] clr_addr_r;
  logic              rd_ok_r;
  logic              hit;
  logic [ADDR_W-1:0] req_addr;
  logic              ram_en;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_addr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic [WORD_BITS-1:0] ram_q;

  assign hit = (sel < SEL_BITS'(SEG_COUNT)) &&
               ({{(32-IDX_BITS){1'b0}}, idx} < 32'(SEGMENT_WORDS));
  assign req_addr = ADDR_W'(32'(sel) * SEGMENT_WORDS + 32'(idx));

  always_comb begin
    if (clearing_r) begin
      ram_en    = 1'b1;
      ram_we    = 1'b1;
      ram_addr  = clr_addr_r;
      ram_wdata = '0;
    end else begin
      ram_en    = (req.wr || req.rd) && hit;
      ram_we    = req.wr;
      ram_addr  = req_addr;
      ram_wdata = wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_addr_r <= '0;
      rd_ok_r    <= 1'b0;
    end else begin
      if (clearing_r) begin
        if (clr_addr_r == ADDR_W'(DEPTH - 1)) begin
          clearing_r <= 1'b0;
        end
        clr_addr_r <= clr_addr_r + ADDR_W'(1);
      end
      rd_ok_r <= req.rd && hit && !clearing_r;
    end
  end

  vmsa_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_q)
  );

  assign rdata    = rd_ok_r ? ram_q : '0;
  assign clearing = clearing_r;

endmodule

// ===== hw/rtl/vm_stack_alu_with_segments.sv =====
// vm_stack_alu_with_segments: stack alu on a row of shift cells plus segment store
// depends on vmsa_pkg, vmsa_cell, vmsa_seg
//
//  channel   ports                                              transfer
//  input     start, busy, in_operation, in_data_value,          start && !busy
//            in_segment_select, in_segment_index
//  result    out_strobe, out_result_value, out_status           out_strobe
//
// one operation per cycle while busy is low; each result appears in the cycle
// after its transfer, the top two words sit in cells 0 and 1 so dependent
// operations need no wait; after reset busy stays high while the segment store
// is swept to zero
// the receiver cannot stall, so busy only reflects that sweep
module vm_stack_alu_with_segments #(
  parameter int STACK_DEPTH   = vmsa_pkg::DEF_STACK_DEPTH,
  parameter int SEGMENT_WORDS = vmsa_pkg::DEF_SEGMENT_WORDS,
  parameter int WORD_BITS     = vmsa_pkg::DEF_WORD_BITS
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic        [vmsa_pkg::OP_BITS-1:0]  in_operation,
  input  logic signed [vmsa_pkg::IO_BITS-1:0]  in_data_value,
  input  logic        [vmsa_pkg::SEL_BITS-1:0] in_segment_select,
  input  logic        [vmsa_pkg::IDX_BITS-1:0] in_segment_index,
  output logic                                 out_strobe,
  output logic signed [vmsa_pkg::IO_BITS-1:0]  out_result_value,
  output logic        [vmsa_pkg::STAT_BITS-1:0] out_status
);
  import vmsa_pkg::*;

  localparam int CNT_W = $clog2(STACK_DEPTH + 1);

  logic                 accept;
  logic                 clearing;
  logic [WORD_BITS-1:0] in_word;
  logic [WORD_BITS-1:0] top_w;
  logic [WORD_BITS-1:0] below_w;
  logic [WORD_BITS-1:0] seg_rdata;
  logic [WORD_BITS-1:0] cell_q [STACK_DEPTH+2];
  logic [WORD_BITS-1:0] up_w   [STACK_DEPTH];
  shift_t               shift;
  shift_t               cell_shift;
  seg_req_t             seg_req;

  logic [CNT_W-1:0]     cnt_r;
  logic [CNT_W-1:0]     cnt_nxt;
  logic [WORD_BITS-1:0] res_nxt;
  logic [IO_BITS-1:0]   res_r;
  logic [STAT_BITS-1:0] st_r;
  logic [STAT_BITS-1:0] st_nxt;
  logic                 strobe_r;
  logic                 seg_rd_r;

  assign accept  = start && !clearing;
  assign busy    = clearing;
  assign in_word = WORD_BITS'(in_data_value);
  assign top_w   = cell_q[0];
  assign below_w = cell_q[1];

  always_comb begin
    shift   = SH_HOLD;
    cnt_nxt = cnt_r;
    res_nxt = '0;
    st_nxt  = ST_OK;
    case (in_operation)
      OP_PUSH: begin
        if (cnt_r == CNT_W'(STACK_DEPTH)) begin
          st_nxt = ST_OVERFLOW;
        end else begin
          shift   = SH_PUSH;
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      OP_POP, OP_NEG, OP_NOT: begin
        if (cnt_r == '0) begin
          st_nxt = ST_UNDERFLOW;
        end else begin
          shift   = SH_POP1;
          cnt_nxt = cnt_r - CNT_W'(1);
          if (in_operation == OP_NEG) begin
            res_nxt = '0 - top_w;
          end else if (in_operation == OP_NOT) begin
            res_nxt = ~top_w;
          end else begin
            res_nxt = top_w;
          end
        end
      end
      OP_ADD, OP_SUB, OP_EQ, OP_GT, OP_LT, OP_AND, OP_OR: begin
        if (cnt_r < CNT_W'(2)) begin
          st_nxt = ST_UNDERFLOW;
        end else begin
          shift   = SH_POP2;
          cnt_nxt = cnt_r - CNT_W'(2);
          case (in_operation)
            OP_ADD:  res_nxt = below_w + top_w;
            OP_SUB:  res_nxt = below_w - top_w;
            OP_EQ:   res_nxt = (below_w == top_w) ? '1 : '0;
            OP_GT:   res_nxt = ($signed(below_w) > $signed(top_w)) ? '1 : '0;
            OP_LT:   res_nxt = ($signed(below_w) < $signed(top_w)) ? '1 : '0;
            OP_AND:  res_nxt = below_w & top_w;
            default: res_nxt = below_w | top_w;
          endcase
        end
      end
      default: begin
        shift = SH_HOLD;
      end
    endcase
  end

  assign cell_shift = accept ? shift : SH_HOLD;
  assign seg_req.wr = accept && (in_operation == OP_SEGWRITE);
  assign seg_req.rd = accept && (in_operation == OP_SEGREAD);

  assign cell_q[STACK_DEPTH]   = '0;
  assign cell_q[STACK_DEPTH+1] = '0;
  assign up_w[0]               = in_word;

  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    if (i > 0) begin : g_up
      assign up_w[i] = cell_q[i-1];
    end
    vmsa_cell #(
      .WORD_BITS (WORD_BITS)
    ) u_cell (
      .clk      (clk),
      .shift    (cell_shift),
      .up_word  (up_w[i]),
      .dn1_word (cell_q[i+1]),
      .dn2_word (cell_q[i+2]),
      .word     (cell_q[i])
    );
  end

  vmsa_seg #(
    .SEGMENT_WORDS (SEGMENT_WORDS),
    .WORD_BITS     (WORD_BITS)
  ) u_seg (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (seg_req),
    .sel      (in_segment_select),
    .idx      (in_segment_index),
    .wdata    (in_word),
    .rdata    (seg_rdata),
    .clearing (clearing)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      strobe_r <= 1'b0;
      seg_rd_r <= 1'b0;
      st_r     <= ST_OK;
    end else begin
      strobe_r <= accept;
      seg_rd_r <= seg_req.rd;
      if (accept) begin
        cnt_r <= cnt_nxt;
        st_r  <= st_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= IO_BITS'(res_nxt);
    end
  end

  assign out_strobe       = strobe_r;
  assign out_status       = st_r;
  assign out_result_value = seg_rd_r ? $signed(IO_BITS'(seg_rdata)) : $signed(res_r);

endmodule

// ===== sim/tb_vm_stack_alu_with_segments.sv =====
`timescale 1ns / 1ps
// tb_vm_stack_alu_with_segments: self-checking bench for the vm stack alu with segments
// directed and random operation streams, each result checked against an in-bench model
// depends on vmsa_pkg and vm_stack_alu_with_segments
module tb_vm_stack_alu_with_segments;
  import vmsa_pkg::*;

  localparam int STACK_WORDS = DEF_STACK_DEPTH;
  localparam int SEG_WORDS   = DEF_SEGMENT_WORDS;
  localparam int CYCLE_LIMIT = 200000;
  localparam int QUIET_TAIL  = 80;
  localparam int RANDOM_OPS  = 20;

  typedef struct packed {
    logic [OP_BITS-1:0]  op;
    logic [IO_BITS-1:0]  data;
    logic [SEL_BITS-1:0] sel;
    logic [IDX_BITS-1:0] idx;
    logic                settle;
  } vm_op_t;

  typedef struct packed {
    logic [IO_BITS-1:0]   value;
    logic [STAT_BITS-1:0] status;
  } vm_result_t;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        start = 1'b0;
  logic                        busy;
  logic        [OP_BITS-1:0]   in_operation = '0;
  logic signed [IO_BITS-1:0]   in_data_value = '0;
  logic        [SEL_BITS-1:0]  in_segment_select = '0;
  logic        [IDX_BITS-1:0]  in_segment_index = '0;
  logic                        out_strobe;
  logic signed [IO_BITS-1:0]   out_result_value;
  logic        [STAT_BITS-1:0] out_status;

  vm_op_t     op_queue[$];
  vm_result_t pending_results[$];

  logic [IO_BITS-1:0] stack_words [STACK_WORDS];
  logic [IO_BITS-1:0] segment_words [SEG_COUNT * SEG_WORDS] = '{default: '0};
  int                 stack_count = 0;

  int                 gen_depth = 0;
  logic [IO_BITS-1:0] last_word = '0;
  int                 gap_left = 0;
  int                 error_count = 0;
  int                 cycle_count = 0;

  vm_stack_alu_with_segments dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_operation      (in_operation),
    .in_data_value     (in_data_value),
    .in_segment_select (in_segment_select),
    .in_segment_index  (in_segment_index),
    .out_strobe        (out_strobe),
    .out_result_value  (out_result_value),
    .out_status        (out_status)
  );

  always #5 clk = ~clk;

  function automatic vm_result_t compute_result(logic [OP_BITS-1:0] op,
                                                logic [IO_BITS-1:0] data,
                                                logic [SEL_BITS-1:0] sel,
                                                logic [IDX_BITS-1:0] idx);
    vm_result_t         r;
    logic [IO_BITS-1:0] top;
    logic [IO_BITS-1:0] below;
    r.value  = '0;
    r.status = ST_OK;
    case (op)
      OP_PUSH: begin
        if (stack_count >= STACK_WORDS) begin
          r.status = ST_OVERFLOW;
        end else begin
          stack_words[stack_count] = data;
          stack_count++;
        end
      end
      OP_POP, OP_NEG, OP_NOT: begin
        if (stack_count < 1) begin
          r.status = ST_UNDERFLOW;
        end else begin
          top = stack_words[stack_count - 1];
          stack_count--;
          if (op == OP_POP) r.value = top;
          else if (op == OP_NEG) r.value = '0 - top;
          else r.value = ~top;
        end
      end
      OP_ADD, OP_SUB, OP_EQ, OP_GT, OP_LT, OP_AND, OP_OR: begin
        if (stack_count < 2) begin
          r.status = ST_UNDERFLOW;
        end else begin
          top   = stack_words[stack_count - 1];
          below = stack_words[stack_count - 2];
          stack_count -= 2;
          case (op)
            OP_ADD: r.value = below + top;
            OP_SUB: r.value = below - top;
            OP_EQ:  r.value = (below == top) ? '1 : '0;
            OP_GT:  r.value = ($signed(below) > $signed(top)) ? '1 : '0;
            OP_LT:  r.value = ($signed(below) < $signed(top)) ? '1 : '0;
            OP_AND: r.value = below & top;
            default: r.value = below | top;
          endcase
        end
      end
      OP_SEGWRITE: begin
        if (sel < SEG_COUNT && idx < SEG_WORDS)
          segment_words[int'(sel) * SEG_WORDS + int'(idx)] = data;
      end
      OP_SEGREAD: begin
        if (sel < SEG_COUNT && idx < SEG_WORDS)
          r.value = segment_words[int'(sel) * SEG_WORDS + int'(idx)];
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic log_mismatch(string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  // generator depth tracks the stack so random streams stay mostly well-formed
  task automatic queue_op(logic [OP_BITS-1:0] op, logic [IO_BITS-1:0] data,
                          logic [SEL_BITS-1:0] sel, logic [IDX_BITS-1:0] idx);
    vm_op_t it;
    it.op     = op;
    it.data   = data;
    it.sel    = sel;
    it.idx    = idx;
    it.settle = 1'b0;
    op_queue.insert(op_queue.size(), it);
    case (op)
      OP_PUSH: if (gen_depth < STACK_WORDS) gen_depth++;
      OP_POP, OP_NEG, OP_NOT: if (gen_depth >= 1) gen_depth--;
      OP_ADD, OP_SUB, OP_EQ, OP_GT, OP_LT, OP_AND, OP_OR: begin
        if (gen_depth >= 2) gen_depth -= 2;
      end
      default: ;
    endcase
  endtask

  function automatic logic [IO_BITS-1:0] pick_word();
    int r;
    r = $urandom_range(0, 15);
    if (r < 4) begin
      return last_word;
    end else if (r < 6) begin
      case ($urandom_range(0, 3))
        0: last_word = 16'h7fff;
        1: last_word = 16'h8000;
        2: last_word = 16'hffff;
        default: last_word = 16'h0000;
      endcase
    end else begin
      last_word = IO_BITS'($urandom);
    end
    return last_word;
  endfunction

  function automatic logic [OP_BITS-1:0] pick_binary_op();
    case ($urandom_range(0, 6))
      0: return OP_ADD;
      1: return OP_SUB;
      2: return OP_EQ;
      3: return OP_GT;
      4: return OP_LT;
      5: return OP_AND;
      default: return OP_OR;
    endcase
  endfunction

  task automatic queue_random_op();
    int                 r;
    logic [OP_BITS-1:0] op;
    logic [IDX_BITS-1:0] idx;
    r = $urandom_range(0, 99);
    if (r < 35 || (gen_depth < 2 && r < 60)) op = OP_PUSH;
    else if (r < 45) op = OP_POP;
    else if (r < 50) op = r[0] ? OP_NEG : OP_NOT;
    else if (r < 80) op = pick_binary_op();
    else if (r < 88) op = OP_SEGWRITE;
    else if (r < 96) op = OP_SEGREAD;
    else op = OP_BITS'($urandom_range(13, 15));
    // a few hot indexes so reads land on written words
    idx = $urandom_range(0, 1) ? IDX_BITS'($urandom_range(0, 3))
                               : IDX_BITS'($urandom_range(0, 255));
    queue_op(op, pick_word(), SEL_BITS'($urandom_range(0, 7)), idx);
  endtask

  always @(posedge clk) begin : drive_p
    vm_op_t nxt;
    logic   load;
    if (!rst_n) begin
      start    <= 1'b0;
      gap_left <= 0;
    end else begin
      if (start && !busy)
        pending_results.insert(pending_results.size(),
                               compute_result(in_operation, in_data_value,
                                              in_segment_select, in_segment_index));
      if (!start || !busy) begin
        load = 1'b0;
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
        end else if (op_queue.size() > 0 &&
                     !(op_queue[0].settle && pending_results.size() > 0)) begin
          if (op_queue.size() > QUIET_TAIL && $urandom_range(0, 5) == 0) begin
            gap_left <= $urandom_range(0, 15);
          end else begin
            nxt = op_queue.pop_front();
            in_operation      <= nxt.op;
            in_data_value     <= nxt.data;
            in_segment_select <= nxt.sel;
            in_segment_index  <= nxt.idx;
            load = 1'b1;
          end
        end
        start <= load;
      end
    end
  end

  always @(posedge clk) begin : check_p
    vm_result_t want;
    if (rst_n && out_strobe === 1'b1) begin
      if (pending_results.size() == 0) begin
        log_mismatch("result transfer with nothing expected");
      end else begin
        want = pending_results.pop_front();
        if (out_result_value !== want.value)
          log_mismatch($sformatf("result_value got %h expected %h",
                                 out_result_value, want.value));
        if (out_status !== want.status)
          log_mismatch($sformatf("status got %0d expected %0d", out_status, want.status));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("vm_stack_alu_with_segments test failed");
      $finish;
    end
  end

  initial begin
    // underflow on empty and one-word stacks, wrap-around, comparisons
    queue_op(OP_POP, 16'h1234, 3'd0, 8'd0);
    queue_op(OP_PUSH, 16'h7fff, 3'd1, 8'd1);
    queue_op(OP_SUB, 16'h0000, 3'd0, 8'd0);
    queue_op(OP_PUSH, 16'h8000, 3'd7, 8'hff);
    queue_op(OP_ADD, 16'hffff, 3'd0, 8'd0);
    queue_op(OP_PUSH, 16'h8000, 3'd0, 8'd0);
    queue_op(OP_NEG, 16'h0000, 3'd0, 8'd0);
    queue_op(OP_PUSH, 16'h8000, 3'd0, 8'd0);
    queue_op(OP_PUSH, 16'h0001, 3'd0, 8'd0);
    queue_op(OP_SUB, 16'h0000, 3'd0, 8'd0);
    queue_op(OP_PUSH, 16'hffff, 3'd0, 8'd0);
    queue_op(OP_PUSH, 16'h0001, 3'd0, 8'd0);
    queue_op(OP_LT, 16'h0000, 3'd0, 8'd0);
    queue_op(OP_PUSH, 16'h0ff0, 3'd0, 8'd0);
    queue_op(OP_NOT, 16'h0000, 3'd0, 8'd0);
    queue_op(OP_PUSH, 16'd123, 3'd0, 8'd0);
    queue_op(OP_PUSH, 16'd123, 3'd0, 8'd0);
    queue_op(OP_EQ, 16'h0000, 3'd0, 8'd0);
    // segment extremes, the unused select and unknown opcodes
    queue_op(OP_SEGWRITE, 16'h8000, 3'd6, 8'hff);
    queue_op(OP_SEGREAD, 16'h0000, 3'd6, 8'hff);
    queue_op(OP_SEGWRITE, 16'h7fff, 3'd7, 8'd0);
    queue_op(OP_SEGREAD, 16'h0000, 3'd7, 8'd0);
    queue_op(OP_SEGREAD, 16'hffff, 3'd0, 8'd0);
    queue_op(4'd15, 16'hffff, 3'd7, 8'hff);
    queue_op(4'd13, 16'h5555, 3'd2, 8'd7);

    for (int i = 0; i < RANDOM_OPS; i++) queue_random_op();
    op_queue[op_queue.size() - RANDOM_OPS].settle = 1'b1;

    // fill to the top, overflow, then drain past empty
    queue_op(OP_PUSH, pick_word(), 3'd0, 8'd0);
    op_queue[op_queue.size() - 1].settle = 1'b1;
    while (gen_depth < STACK_WORDS)
      queue_op(OP_PUSH, pick_word(), SEL_BITS'($urandom), IDX_BITS'($urandom));
    repeat (3) queue_op(OP_PUSH, pick_word(), SEL_BITS'($urandom), IDX_BITS'($urandom));
    while (gen_depth > 0) begin
      if (gen_depth >= 2 && $urandom_range(0, 7) != 0)
        queue_op(pick_binary_op(), pick_word(), 3'd0, 8'd0);
      else
        queue_op(OP_BITS'($urandom_range(0, 2) == 0 ? OP_NEG : OP_POP), pick_word(),
                 3'd0, 8'd0);
    end
    queue_op(OP_POP, 16'h0000, 3'd0, 8'd0);
    queue_op(OP_NOT, 16'h0000, 3'd0, 8'd0);
    queue_op(OP_OR, 16'h0000, 3'd0, 8'd0);

    for (int i = 0; i < RANDOM_OPS; i++) queue_random_op();

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while (op_queue.size() > 0 || start) @(posedge clk);
    while (pending_results.size() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (error_count == 0) begin
      $display("vm_stack_alu_with_segments test passed");
    end else begin
      $display("vm_stack_alu_with_segments test failed");
    end
    $finish;
  end

endmodule
